@@ design/mandelbrot_escape_time_assert.svh @@
// Assertion macros for the escape-time block checkers.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MBE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mbe_pkg.sv @@
// Package: types, constants and helpers for the escape-time block.
package mbe_pkg;

    localparam int FRAC_BITS      = 28;
    localparam int ESCAPE_RADIUS  = 2;
    localparam int COORD_W        = 32;
    localparam int STEP_W         = 31;
    localparam int COUNT_W        = 16;
    localparam int INDEX_W        = 10;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int SQ_W           = PROD_W - 1 - FRAC_BITS;
    localparam int MAG_W          = SQ_W + 1;
    localparam int SUM_W          = 44;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [MAG_W-1:0] ESCAPE_LIMIT =
        MAG_W'(ESCAPE_RADIUS * ESCAPE_RADIUS) << FRAC_BITS;

    localparam logic signed [COORD_W-1:0] RST_CORNER_RE  = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_CORNER_IM  = -32'sd335544320;
    localparam logic [STEP_W-1:0]         RST_PIXEL_STEP = 31'd1677721;
    localparam logic [COUNT_W-1:0]        RST_MAX_ITER   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER_RE  = 2'd0,
        REG_CORNER_IM  = 2'd1,
        REG_PIXEL_STEP = 2'd2,
        REG_MAX_ITER   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner_re;
        logic signed [COORD_W-1:0] corner_im;
        logic [STEP_W-1:0]         pixel_step;
        logic [COUNT_W-1:0]        max_iterations;
    } mbe_cfg_t;

    typedef struct packed {
        logic setup;
        logic mul_en;
        logic load_c;
        logic clear_z;
        logic update_z;
    } mbe_ctrl_t;

    // Clamp a wide signed sum to the Q4.28 range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COORD_W:0] top;
        top = v[SUM_W-1:COORD_W-1];
        if (top == '0 || top == '1)
            return v[COORD_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

@@ design/mbe_pixel_if.sv @@
// Pixel channel interface: row and column of one pixel.
interface mbe_pixel_if
    import mbe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

@@ design/mbe_result_if.sv @@
// Result channel interface: pixel position and iteration count.
interface mbe_result_if
    import mbe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] row_out;
    logic [INDEX_W-1:0] col_out;
    logic [COUNT_W-1:0] iteration_count;

    modport source (output valid, output row_out, output col_out,
                    output iteration_count, input ready);
    modport sink   (input valid, input row_out, input col_out,
                    input iteration_count, output ready);
endinterface

@@ design/mandelbrot_escape_time.sv @@
// Top level of the Mandelbrot escape-time pixel block.
//
//   channel | dir | transaction                         | handshake
//   pixel   | in  | row, col                            | valid/ready
//   result  | out | row_out, col_out, iteration_count   | valid/ready
//   cfg     | in  | cfg_index, cfg_wdata                | cfg_we
//
// After acceptance the sequencer runs S_SETUP_MUL and S_SETUP_ADD for the start point, then
// S_ITER_MUL and S_ITER_UPD per iteration until the count reaches max_iterations or z escapes,
// and S_FINISH to hand off, after which it returns to S_IDLE.
// rst_n clears the sequencer, output valid and configuration to their defaults.
// A stalled result holds in the output register; the next pixel is accepted
// meanwhile and waits at its finish until the register frees.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mbe_pixel_if.sink             pixel,
    mbe_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP_MUL,
        S_SETUP_ADD,
        S_ITER_MUL,
        S_ITER_UPD,
        S_FINISH
    } state_t;

    state_t             state_reg,   state_next;
    logic [INDEX_W-1:0] row_reg,     row_next;
    logic [INDEX_W-1:0] col_reg,     col_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               ovalid_reg,  ovalid_next;
    logic [INDEX_W-1:0] orow_reg,    orow_next;
    logic [INDEX_W-1:0] ocol_reg,    ocol_next;
    logic [COUNT_W-1:0] ocount_reg,  ocount_next;

    mbe_cfg_t  cfg;
    mbe_ctrl_t ctrl;
    logic      escape;

    mbe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbe_datapath u_datapath (
        .clk    (clk),
        .ctrl   (ctrl),
        .cfg    (cfg),
        .row    (row_reg),
        .col    (col_reg),
        .escape (escape)
    );

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg && !result.ready;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        ocount_next = ocount_reg;
        ctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (pixel.valid)
                begin
                    row_next   = pixel.row;
                    col_next   = pixel.col;
                    state_next = S_SETUP_MUL;
                end
            end
            S_SETUP_MUL:
            begin
                ctrl.setup  = 1'b1;
                ctrl.mul_en = 1'b1;
                state_next  = S_SETUP_ADD;
            end
            S_SETUP_ADD:
            begin
                ctrl.load_c  = 1'b1;
                ctrl.clear_z = 1'b1;
                count_next   = '0;
                state_next   = S_ITER_MUL;
            end
            S_ITER_MUL:
            begin
                if (count_reg >= cfg.max_iterations)
                    state_next = S_FINISH;
                else
                begin
                    ctrl.mul_en = 1'b1;
                    state_next  = S_ITER_UPD;
                end
            end
            S_ITER_UPD:
            begin
                if (escape)
                    state_next = S_FINISH;
                else
                begin
                    ctrl.update_z = 1'b1;
                    count_next    = count_reg + COUNT_W'(1);
                    state_next    = S_ITER_MUL;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register frees.
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    orow_next   = row_reg;
                    ocol_next   = col_reg;
                    ocount_next = count_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            ocount_reg <= ocount_next;
        end
    end

    assign pixel.ready            = (state_reg == S_IDLE);
    assign result.valid           = ovalid_reg;
    assign result.row_out         = orow_reg;
    assign result.col_out         = ocol_reg;
    assign result.iteration_count = ocount_reg;

endmodule

@@ design/mbe_cfg.sv @@
// Configuration register file for the escape-time block.
module mbe_cfg
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output mbe_cfg_t              cfg
);

    mbe_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.corner_re      <= RST_CORNER_RE;
            cfg_reg.corner_im      <= RST_CORNER_IM;
            cfg_reg.pixel_step     <= RST_PIXEL_STEP;
            cfg_reg.max_iterations <= RST_MAX_ITER;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_CORNER_RE:  cfg_reg.corner_re      <= signed'(cfg_wdata[COORD_W-1:0]);
                REG_CORNER_IM:  cfg_reg.corner_im      <= signed'(cfg_wdata[COORD_W-1:0]);
                REG_PIXEL_STEP: cfg_reg.pixel_step     <= cfg_wdata[STEP_W-1:0];
                REG_MAX_ITER:   cfg_reg.max_iterations <= cfg_wdata[COUNT_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/mbe_datapath.sv @@
// Shared complex-square datapath: three multipliers, adders and saturation.
module mbe_datapath
    import mbe_pkg::*;
(
    input  logic               clk,
    input  mbe_ctrl_t          ctrl,
    input  mbe_cfg_t           cfg,
    input  logic [INDEX_W-1:0] row,
    input  logic [INDEX_W-1:0] col,
    output logic               escape
);

    logic signed [COORD_W-1:0] zr_reg;
    logic signed [COORD_W-1:0] zi_reg;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [PROD_W-1:0]  p0_reg;
    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p2_reg;

    logic signed [COORD_W-1:0] op_a0;
    logic signed [COORD_W-1:0] op_b0;
    logic signed [COORD_W-1:0] op_a1;
    logic signed [COORD_W-1:0] op_b1;
    logic signed [COORD_W-1:0] step_s;
    logic signed [PROD_W-1:0]  prod0;
    logic signed [PROD_W-1:0]  prod1;
    logic signed [PROD_W-1:0]  prod2;

    logic [SQ_W-1:0]           zr2;
    logic [SQ_W-1:0]           zi2;
    logic [MAG_W-1:0]          mag;
    logic signed [SUM_W-1:0]   re_sum;
    logic signed [SUM_W-1:0]   im_sum;
    logic signed [SUM_W-1:0]   cr_sum;
    logic signed [SUM_W-1:0]   ci_sum;

    // Setup reuses the first two multipliers for col*step and row*step.
    assign step_s = signed'({1'b0, cfg.pixel_step});
    assign op_a0  = ctrl.setup ? signed'(COORD_W'(col)) : zr_reg;
    assign op_b0  = ctrl.setup ? step_s : zr_reg;
    assign op_a1  = ctrl.setup ? signed'(COORD_W'(row)) : zi_reg;
    assign op_b1  = ctrl.setup ? step_s : zi_reg;

    assign prod0 = op_a0 * op_b0;
    assign prod1 = op_a1 * op_b1;
    assign prod2 = zr_reg * zi_reg;

    assign zr2    = p0_reg[PROD_W-2:FRAC_BITS];
    assign zi2    = p1_reg[PROD_W-2:FRAC_BITS];
    assign mag    = {1'b0, zr2} + {1'b0, zi2};
    assign escape = (mag >= ESCAPE_LIMIT);

    assign re_sum = signed'(SUM_W'(zr2)) - signed'(SUM_W'(zi2)) + SUM_W'(cr_reg);
    assign im_sum = SUM_W'(signed'(p2_reg[PROD_W-1:FRAC_BITS-1])) + SUM_W'(ci_reg);
    assign cr_sum = SUM_W'(cfg.corner_re) + signed'(SUM_W'(p0_reg[PROD_W-2:0]));
    assign ci_sum = SUM_W'(cfg.corner_im) + signed'(SUM_W'(p1_reg[PROD_W-2:0]));

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p0_reg <= prod0;
            p1_reg <= prod1;
            p2_reg <= prod2;
        end
        if (ctrl.load_c)
        begin
            cr_reg <= sat32(cr_sum);
            ci_reg <= sat32(ci_sum);
        end
        if (ctrl.clear_z)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (ctrl.update_z)
        begin
            zr_reg <= sat32(re_sum);
            zi_reg <= sat32(im_sum);
        end
    end

endmodule

@@ design/mbe_checker.sv @@
// Port checker for the escape-time block and its bind to the top level.
`include "mandelbrot_escape_time_assert.svh"

module mbe_checker
    import mbe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pixel_valid,
    input logic               pixel_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [INDEX_W-1:0] row_out,
    input logic [INDEX_W-1:0] col_out,
    input logic [COUNT_W-1:0] iteration_count
);

    logic pixel_take;
    logic result_stall;

    assign pixel_take   = pixel_valid && pixel_ready;
    assign result_stall = result_valid && !result_ready;

    `MBE_ASSERT_NEXT(a_result_hold, clk, rst_n, result_stall, result_valid, "result valid dropped while stalled")

    `MBE_ASSERT_NEXT(a_result_stable, clk, rst_n, result_stall, $stable(row_out) && $stable(col_out) && $stable(iteration_count), "result transaction changed while stalled")

    `MBE_ASSERT_IMPL(a_busy_after_take, clk, rst_n, pixel_take, ##1 !pixel_ready ##1 !pixel_ready, "pixel accepted again during setup")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pixel_valid     (pixel.valid),
    .pixel_ready     (pixel.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .row_out         (result.row_out),
    .col_out         (result.col_out),
    .iteration_count (result.iteration_count)
);
